[sv/bfdt_pkg.sv]
package bfdt_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int FLOW_CNT_W  = 7;

	// One packet header; this is also the layout of a stored entry.
	typedef struct packed {
		logic [7:0]  protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} pkt_t;

	// One lookup result.
	typedef struct packed {
		logic                  is_new;
		logic                  table_full;
		logic [FLOW_CNT_W-1:0] flow_count;
	} res_t;

	// Access request from the scan controller to the entry store.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
	} store_req_t;

endpackage

[sv/bidirectional_flow_dedup_table_top.sv]
// Channel  Direction  Transfer condition      Payload
// command  in         start && !busy          pkt (protocol, addresses, ports)
// result   out        done (one cycle only)   res (is_new, table_full, flow_count)
//
// Entries fill from index 0 upwards and are never removed, so the stored
// count marks which entries are valid. An item walks the stored entries one
// per cycle through the single read port of the entry memory; busy stays
// high until the last compare is absorbed. The result strobe is high in the
// first cycle with busy low, and a new command may be taken in that same
// cycle. Reset empties the table at once; no clearing pass is needed. The
// receiver cannot stall results.
module bidirectional_flow_dedup_table_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bfdt_pkg::pkt_t pkt,
	output logic           busy,
	output logic           done,
	output bfdt_pkg::res_t res
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                       state_q;
	logic [bfdt_pkg::CNT_W-1:0] count_q;
	logic [bfdt_pkg::CNT_W-1:0] addr_q;
	logic                       hit_q;
	logic                       rd_last_q;
	logic                       done_q;
	bfdt_pkg::res_t             res_q;
	bfdt_pkg::pkt_t             pkt_q;
	bfdt_pkg::store_req_t       req;
	logic                       hit;
	logic                       accept;
	logic                       issue;
	logic                       finish;
	logic                       store_new;
	logic [bfdt_pkg::CNT_W-1:0] count_inc;

	assign accept    = start && (state_q == ST_IDLE);
	assign issue     = (state_q == ST_SCAN) && (addr_q < count_q);
	// The walk ends once every read is issued and its compare absorbed; a read
	// issued in the previous cycle still has its compare to come.
	assign finish    = (state_q == ST_SCAN) && !issue && !rd_last_q;
	assign store_new = finish && !hit_q &&
		(count_q < bfdt_pkg::CNT_W'(bfdt_pkg::TABLE_DEPTH));
	assign count_inc = bfdt_pkg::CNT_W'(count_q + 1'b1);

	// Store access requests.
	always_comb begin
		req.rd_en   = issue;
		req.rd_addr = addr_q[bfdt_pkg::IDX_W-1:0];
		req.wr_en   = store_new;
		req.wr_addr = count_q[bfdt_pkg::IDX_W-1:0];
	end

	bfdt_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.key    (pkt_q),
		.hit    (hit)
	);

	// Header captured on transfer, held for the whole walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_q <= pkt;
		end
	end

	// Scan control, hit accumulation and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			addr_q    <= '0;
			hit_q     <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			rd_last_q <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						addr_q  <= '0;
						hit_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						addr_q <= bfdt_pkg::CNT_W'(addr_q + 1'b1);
					end
					if (hit) begin
						hit_q <= 1'b1;
					end
					if (finish) begin
						state_q <= ST_IDLE;
					end
					if (store_new) begin
						count_q <= count_inc;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result strobe, valid for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (finish) begin
			res_q.is_new     <= store_new;
			res_q.table_full <= !hit_q && !store_new;
			res_q.flow_count <= store_new ? bfdt_pkg::FLOW_CNT_W'(count_inc)
				: bfdt_pkg::FLOW_CNT_W'(count_q);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// A result is never both new and a full-table miss.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res.is_new && res.table_full))
		else $error("is_new and table_full raised together");

	// The fill count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bfdt_pkg::CNT_W'(bfdt_pkg::TABLE_DEPTH))
		else $error("stored count exceeds table depth");

	// A full-table miss is only reported with every entry in use.
	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.table_full) |-> (count_q == bfdt_pkg::CNT_W'(bfdt_pkg::TABLE_DEPTH)))
		else $error("table_full reported with free entries");

	// A new connection raises the fill count by exactly one.
	a_new_counts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) && res.is_new |-> count_q == bfdt_pkg::CNT_W'($past(count_q) + 1'b1))
		else $error("new connection not counted once");

	// A transfer always starts a walk.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not start a walk");

endmodule

[sv/bfdt_store.sv]
module bfdt_store (
	input  logic                clk,
	input  logic                arst_n,
	input  bfdt_pkg::store_req_t req,
	input  bfdt_pkg::pkt_t      key,
	output logic                hit
);

	// Entry memory: one write port, one registered read port.
	bfdt_pkg::pkt_t mem [bfdt_pkg::TABLE_DEPTH];
	bfdt_pkg::pkt_t rd_data_s1;
	logic           rd_valid_s1;
	logic           fwd_match;
	logic           rev_match;

	// Writes store the current key; reads return the entry in the next cycle.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= key;
		end
		if (req.rd_en) begin
			rd_data_s1 <= mem[req.rd_addr];
		end
	end

	// Marks the cycle in which read data belongs to an issued read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= req.rd_en;
		end
	end

	// Compare the entry against the key in both directions.
	assign fwd_match = (rd_data_s1.protocol == key.protocol) &&
		(rd_data_s1.source_address == key.source_address) &&
		(rd_data_s1.dest_address == key.dest_address) &&
		(rd_data_s1.source_port == key.source_port) &&
		(rd_data_s1.dest_port == key.dest_port);

	assign rev_match = (rd_data_s1.protocol == key.protocol) &&
		(rd_data_s1.source_address == key.dest_address) &&
		(rd_data_s1.dest_address == key.source_address) &&
		(rd_data_s1.source_port == key.dest_port) &&
		(rd_data_s1.dest_port == key.source_port);

	assign hit = rd_valid_s1 && (fwd_match || rev_match);

endmodule

[sim/bidirectional_flow_dedup_table_top_test.sv]
module bidirectional_flow_dedup_table_top_test;
	import bfdt_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 500;
	localparam int PAUSE_ITEM   = 250;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
	localparam int MAX_REPORTS  = 10;
	localparam int PKT_W        = $bits(pkt_t);

	// One row of the directed stimulus; typed rows carry their own outcome.
	typedef struct {
		pkt_t tuple;
		bit   typed;
		res_t outcome;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	pkt_t pkt    = '0;
	logic busy;
	logic done;
	res_t res;

	// Private copy of the connection table used for prediction.
	pkt_t mirror_tuple [TABLE_DEPTH];
	bit   mirror_valid [TABLE_DEPTH];
	int   mirror_count = 0;

	res_t      pending_results [$];
	pkt_t      sent_flows [$];
	stim_row_t directed_rows [$];
	int        mismatches = 0;
	int        cycles     = 0;
	int        item_count = 0;

	bidirectional_flow_dedup_table_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.pkt    (pkt),
		.busy   (busy),
		.done   (done),
		.res    (res)
	);

	// Free-running clock.
	initial begin
		forever #2 clk = ~clk;
	end

	// Give up if the run never completes.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic pkt_t flow_of(input logic [7:0] proto, input logic [31:0] saddr,
		input logic [31:0] daddr, input logic [15:0] sport, input logic [15:0] dport);
		pkt_t p;
		p.protocol       = proto;
		p.source_address = saddr;
		p.dest_address   = daddr;
		p.source_port    = sport;
		p.dest_port      = dport;
		return p;
	endfunction

	// The same connection seen from the other end.
	function automatic pkt_t swap_flow(input pkt_t p);
		return flow_of(p.protocol, p.dest_address, p.source_address, p.dest_port,
			p.source_port);
	endfunction

	// Looks the header up in the mirror table and stores it on a miss.
	function automatic res_t lookup_flow(input pkt_t p);
		res_t r;
		bit   hit;
		bit   have_free;
		int   free_slot;
		pkt_t rev;
		hit       = 1'b0;
		have_free = 1'b0;
		free_slot = 0;
		rev       = swap_flow(p);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (mirror_valid[i]) begin
				if (mirror_tuple[i] == p || mirror_tuple[i] == rev)
					hit = 1'b1;
			end else if (!have_free) begin
				have_free = 1'b1;
				free_slot = i;
			end
		end
		r = '0;
		if (!hit) begin
			if (have_free) begin
				mirror_valid[free_slot] = 1'b1;
				mirror_tuple[free_slot] = p;
				mirror_count++;
				r.is_new = 1'b1;
			end else begin
				r.table_full = 1'b1;
			end
		end
		r.flow_count = mirror_count[FLOW_CNT_W-1:0];
		return r;
	endfunction

	task automatic add_row(input pkt_t p, input bit typed, input bit fresh, input bit full,
		input int count);
		stim_row_t row;
		row.tuple              = p;
		row.typed              = typed;
		row.outcome.is_new     = fresh;
		row.outcome.table_full = full;
		row.outcome.flow_count = count[FLOW_CNT_W-1:0];
		directed_rows.push_back(row);
	endtask

	// Field value biased towards the extremes.
	function automatic logic [31:0] field_bits();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		else
			return $urandom();
	endfunction

	// Mostly repeats of known connections in either direction, some fresh
	// headers and some near misses of a known one.
	function automatic pkt_t random_flow();
		pkt_t           base;
		logic [31:0]    a;
		logic [31:0]    b;
		logic [31:0]    c;
		logic [PKT_W-1:0] v;
		int             pick;
		int             bitpos;
		pick = $urandom_range(0, 99);
		if (sent_flows.size() == 0 || pick < 30) begin
			a = field_bits();
			b = field_bits();
			c = field_bits();
			return flow_of(a[7:0], field_bits(), field_bits(), b[15:0], c[15:0]);
		end
		base = sent_flows[$urandom_range(0, sent_flows.size() - 1)];
		if (pick < 65)
			return base;
		if (pick < 90)
			return swap_flow(base);
		v         = base;
		bitpos    = $urandom_range(0, PKT_W - 1);
		v[bitpos] = ~v[bitpos];
		return pkt_t'(v);
	endfunction

	// Presents one header and waits for its transfer; the expectation is queued
	// at the accepting edge.
	task automatic issue(input pkt_t p, input bit typed, input res_t outcome, input bit hold);
		res_t predicted;
		int   gap;
		if ((item_count % 128) < 40)
			gap = 0;
		else
			gap = $urandom_range(0, 4);
		if (hold || gap != 0) begin
			start <= 1'b0;
			while (hold && pending_results.size() != 0)
				@(posedge clk);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pkt   <= p;
		do
			@(posedge clk);
		while (busy);
		predicted = lookup_flow(p);
		pending_results.push_back(typed ? outcome : predicted);
		sent_flows.push_back(p);
		item_count++;
	endtask

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: is_new=%0d table_full=%0d flow_count=%0d",
						res.is_new, res.table_full, res.flow_count);
			end else begin
				want = pending_results.pop_front();
				if (res.is_new !== want.is_new || res.table_full !== want.table_full ||
						res.flow_count !== want.flow_count) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display(
							"mismatch: expected new=%0d full=%0d count=%0d, got new=%0d full=%0d count=%0d",
							want.is_new, want.table_full, want.flow_count,
							res.is_new, res.table_full, res.flow_count);
				end
			end
		end
	end

	// Reset, directed rows, random items, then drain.
	initial begin : stimulus
		res_t none;
		none = '0;

		// Directed rows: first flow, repeats, both directions, extremes, a flow
		// equal to its own swap, a change of protocol, partial swaps and a
		// one-bit near miss.
		add_row(flow_of(8'd6, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80),
			1'b1, 1'b1, 1'b0, 1);
		add_row(flow_of(8'd6, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80),
			1'b1, 1'b0, 1'b0, 1);
		add_row(flow_of(8'd6, 32'h0A000002, 32'h0A000001, 16'd80, 16'd1234),
			1'b1, 1'b0, 1'b0, 1);
		add_row(flow_of(8'h00, 32'h0, 32'h0, 16'h0, 16'h0), 1'b1, 1'b1, 1'b0, 2);
		add_row(flow_of(8'h00, 32'h0, 32'h0, 16'h0, 16'h0), 1'b1, 1'b0, 1'b0, 2);
		add_row(flow_of(8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF),
			1'b1, 1'b1, 1'b0, 3);
		add_row(flow_of(8'd17, 32'hC0A80001, 32'hC0A80001, 16'd53, 16'd53),
			1'b1, 1'b1, 1'b0, 4);
		add_row(flow_of(8'd17, 32'hC0A80001, 32'hC0A80001, 16'd53, 16'd53),
			1'b1, 1'b0, 1'b0, 4);
		add_row(flow_of(8'd17, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd80),
			1'b1, 1'b1, 1'b0, 5);
		// Addresses swapped but ports kept: a different connection.
		add_row(flow_of(8'd6, 32'h0A000002, 32'h0A000001, 16'd1234, 16'd80),
			1'b1, 1'b1, 1'b0, 6);
		// Ports swapped but addresses kept: the reverse of the previous row.
		add_row(flow_of(8'd6, 32'h0A000001, 32'h0A000002, 16'd80, 16'd1234),
			1'b1, 1'b0, 1'b0, 6);
		add_row(flow_of(8'd6, 32'h0A000001, 32'h0A000002, 16'd1234, 16'd81),
			1'b1, 1'b1, 1'b0, 7);
		add_row(flow_of(8'h80, 32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0), 1'b1, 1'b1, 1'b0, 8);
		add_row(flow_of(8'h80, 32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF), 1'b1, 1'b0, 1'b0, 8);
		add_row(flow_of(8'h01, 32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF), 1'b1, 1'b1, 1'b0, 9);
		add_row(flow_of(8'h7F, 32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 16'h8000),
			1'b0, 1'b0, 1'b0, 0);
		add_row(flow_of(8'h7F, 32'h80000000, 32'h7FFFFFFF, 16'h8000, 16'h7FFF),
			1'b0, 1'b0, 1'b0, 0);
		for (int i = 0; i < 4; i++)
			add_row(flow_of(8'($urandom_range(0, 255)), $urandom(), $urandom(),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))),
				1'b0, 1'b0, 1'b0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].tuple, directed_rows[i].typed, directed_rows[i].outcome,
				1'b0);

		// Random part; the table fills and then reports full on every miss.
		for (int i = 0; i < RANDOM_ITEMS; i++)
			issue(random_flow(), 1'b0, none, i == PAUSE_ITEM);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
